[sv/wes_pkg.sv]
package wes_pkg;

  typedef logic signed [31:0] value_t;
  typedef logic signed [34:0] lap_t;
  typedef logic signed [53:0] prod_t;
  typedef logic signed [39:0] term_t;
  typedef logic signed [40:0] sum_t;

  localparam int NumLanes = 3;
  typedef logic [NumLanes-1:0] lane_mask_t;

  typedef enum logic [2:0] {
    REG_ROW_WIDTH  = 3'd0,
    REG_ROW_COUNT  = 3'd1,
    REG_COEF_X     = 3'd2,
    REG_COEF_Y     = 3'd3,
    REG_FIRST_MIRR = 3'd4,
    REG_LAST_MIRR  = 3'd5
  } reg_idx_e;

  localparam int AddrWidth = 5;

  localparam logic [10:0] RowWidthRst = 11'd64;
  localparam logic [12:0] RowCountRst = 13'd64;

  localparam sum_t SatMax = 41'sd2147483647;
  localparam sum_t SatMin = -41'sd2147483648;

endpackage

[sv/wes_in_if.sv]
interface wes_in_if;
  logic            valid;
  logic            ready;
  wes_pkg::value_t cur_value;
  wes_pkg::value_t prev_value;

  modport source (output valid, cur_value, prev_value, input ready);
  modport sink (input valid, cur_value, prev_value, output ready);
endinterface

[sv/wes_out_if.sv]
interface wes_out_if;
  logic            valid;
  logic            ready;
  wes_pkg::value_t new_value;
  logic            grid_done;

  modport source (output valid, new_value, grid_done, input ready);
  modport sink (input valid, new_value, grid_done, output ready);
endinterface

[sv/wave_equation_stencil_step.sv]
// An accepted item passes stage 1, stages 2 to 4 and the output stage in order.
// Throughput: one item per cycle while the output port takes each result; on a mirrored
//   last row each item past the first column gives two results (three on the final
//   point), so the output port sets the pace there.
// Line buffers are three single-port-write RAMs of MAX_WIDTH words.
// Reset (rst_ni low, async): positions, pipeline valids and registers to
//   defaults; line buffers are not cleared.
module wave_equation_stencil_step #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wes_in_if.sink                         in_i,
  wes_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wes_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_ROWS);

  // configuration
  logic [10:0] row_width_q;
  logic [12:0] row_count_q;
  logic [17:0] coef_x_q, coef_y_q;
  logic        first_mirr_q, last_mirr_q;
  logic        cfg_wr, geo_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign geo_wr = cfg_wr && (paddr[4:2] == wes_pkg::REG_ROW_WIDTH ||
                             paddr[4:2] == wes_pkg::REG_ROW_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= wes_pkg::RowWidthRst;
      row_count_q  <= wes_pkg::RowCountRst;
      coef_x_q     <= '0;
      coef_y_q     <= '0;
      first_mirr_q <= 1'b1;
      last_mirr_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        wes_pkg::REG_ROW_WIDTH:  row_width_q  <= pwdata[10:0];
        wes_pkg::REG_ROW_COUNT:  row_count_q  <= pwdata[12:0];
        wes_pkg::REG_COEF_X:     coef_x_q     <= pwdata[17:0];
        wes_pkg::REG_COEF_Y:     coef_y_q     <= pwdata[17:0];
        wes_pkg::REG_FIRST_MIRR: first_mirr_q <= pwdata[0];
        wes_pkg::REG_LAST_MIRR:  last_mirr_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      wes_pkg::REG_ROW_WIDTH:  prdata = {21'd0, row_width_q};
      wes_pkg::REG_ROW_COUNT:  prdata = {19'd0, row_count_q};
      wes_pkg::REG_COEF_X:     prdata = {14'd0, coef_x_q};
      wes_pkg::REG_COEF_Y:     prdata = {14'd0, coef_y_q};
      wes_pkg::REG_FIRST_MIRR: prdata = {31'd0, first_mirr_q};
      wes_pkg::REG_LAST_MIRR:  prdata = {31'd0, last_mirr_q};
      default:                 prdata = '0;
    endcase
  end

  // geometry
  logic [CW-1:0] wlast;
  logic [RW-1:0] rlast;

  always_comb begin
    if (row_width_q < 11'd2)              wlast = CW'(1);
    else if (32'(row_width_q) > MAX_WIDTH) wlast = CW'(MAX_WIDTH - 1);
    else                                   wlast = CW'(row_width_q - 11'd1);
    if (row_count_q < 13'd3)              rlast = RW'(2);
    else if (32'(row_count_q) > MAX_ROWS)  rlast = RW'(MAX_ROWS - 1);
    else                                   rlast = RW'(row_count_q - 13'd1);
  end

  // position and lane selection for the incoming item
  logic [CW-1:0] col_q, col_d, rd_col;
  logic [RW-1:0] row_q, row_d;
  logic          acc, c_first, c_last, c_one, r_one, r_last;
  wes_pkg::lane_mask_t in_mask;

  assign c_first = (col_q == '0);
  assign c_last  = (col_q == wlast);
  assign c_one   = (col_q == CW'(1));
  assign r_one   = (row_q == RW'(1));
  assign r_last  = (row_q == rlast);
  assign rd_col  = c_last ? '0 : col_q + 1'b1;

  assign in_mask[0] = (row_q != '0) && (!r_one || first_mirr_q);
  assign in_mask[1] = r_last && last_mirr_q && !c_first;
  assign in_mask[2] = r_last && last_mirr_q && c_last;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geo_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      col_d = rd_col;
      if (c_last) row_d = r_last ? '0 : row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line buffer reads and neighbor history
  logic [31:0] newer_mem [MAX_WIDTH];
  logic [31:0] older_mem [MAX_WIDTH];
  logic [31:0] prior_mem [MAX_WIDTH];

  logic [31:0] rn_q, ro_q, rp_q;
  wes_pkg::value_t s1_u_q, s1_p_q, s1_hu1_q, s1_hu2_q, s1_hp1_q, s1_w0_q, s1_w1_q;
  logic s1_cf_q, s1_cl_q, s1_c1_q, s1_r1_q, s1_last_q;
  wes_pkg::lane_mask_t s1_mask_q, s2_mask_q, s3_mask_q, s4_mask_q, o_mask_q;
  logic s2_last_q, s3_last_q, s4_last_q, o_last_q;
  logic en2, en3, en4, en5;

  assign in_i.ready = (s1_mask_q == '0) || en2;
  assign acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rn_q <= newer_mem[rd_col];
      ro_q <= older_mem[col_q];
      rp_q <= prior_mem[col_q];
      newer_mem[col_q] <= in_i.cur_value;
      older_mem[col_q] <= rn_q;
      prior_mem[col_q] <= in_i.prev_value;
      s1_w0_q   <= rn_q;
      s1_w1_q   <= s1_w0_q;
      s1_u_q    <= in_i.cur_value;
      s1_p_q    <= in_i.prev_value;
      s1_hu1_q  <= s1_u_q;
      s1_hu2_q  <= s1_hu1_q;
      s1_hp1_q  <= s1_p_q;
      s1_cf_q   <= c_first;
      s1_cl_q   <= c_last;
      s1_c1_q   <= c_one;
      s1_r1_q   <= r_one;
      s1_last_q <= c_last && r_last;
    end
  end

  // stage 2: laplacian terms per lane
  wes_pkg::value_t ctr [3], lf [3], rt [3], bl [3], ab [3], pv [3];
  wes_pkg::lap_t   lx_d [3], ly_d [3], base_d [3];
  wes_pkg::lap_t   s2_lx_q [3], s2_ly_q [3], s2_base_q [3];

  always_comb begin
    ctr[0] = s1_w0_q;
    lf[0]  = s1_cf_q ? wes_pkg::value_t'(rn_q) : s1_w1_q;
    rt[0]  = s1_cl_q ? s1_w1_q : wes_pkg::value_t'(rn_q);
    bl[0]  = s1_r1_q ? s1_u_q : wes_pkg::value_t'(ro_q);
    ab[0]  = s1_u_q;
    pv[0]  = wes_pkg::value_t'(rp_q);
    ctr[1] = s1_hu1_q;
    lf[1]  = s1_c1_q ? s1_u_q : s1_hu2_q;
    rt[1]  = s1_u_q;
    bl[1]  = s1_w1_q;
    ab[1]  = s1_w1_q;
    pv[1]  = s1_hp1_q;
    ctr[2] = s1_u_q;
    lf[2]  = s1_hu1_q;
    rt[2]  = s1_hu1_q;
    bl[2]  = s1_w0_q;
    ab[2]  = s1_w0_q;
    pv[2]  = s1_p_q;
    for (int i = 0; i < 3; i++) begin
      lx_d[i]   = 35'(lf[i]) + 35'(rt[i]) - (35'(ctr[i]) <<< 1);
      ly_d[i]   = 35'(bl[i]) + 35'(ab[i]) - (35'(ctr[i]) <<< 1);
      base_d[i] = (35'(ctr[i]) <<< 1) - 35'(pv[i]);
    end
  end

  // stage 3: coefficient products
  wes_pkg::prod_t s3_px_q [3], s3_py_q [3];
  wes_pkg::lap_t  s3_base_q [3];
  // stage 4: rounded sum
  wes_pkg::term_t s4_term_q [3];
  wes_pkg::lap_t  s4_base_q [3];
  // output stage
  wes_pkg::value_t o_res_q [3];
  wes_pkg::term_t  term_d [3];
  wes_pkg::sum_t   res_d [3];
  wes_pkg::value_t sat_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term_d[i] = 40'((56'(s3_px_q[i]) + 56'(s3_py_q[i]) + 56'sd32768) >>> 16);
      res_d[i]  = 41'(s4_base_q[i]) + 41'(s4_term_q[i]);
      if (res_d[i] > wes_pkg::SatMax)      sat_d[i] = 32'sh7fffffff;
      else if (res_d[i] < wes_pkg::SatMin) sat_d[i] = 32'sh80000000;
      else                                 sat_d[i] = 32'(res_d[i]);
    end
  end

  logic o_hs, o_single;
  assign o_single = (o_mask_q & (o_mask_q - 1'b1)) == '0;
  assign o_hs     = out_o.valid && out_o.ready;
  assign en5 = (o_mask_q == '0) || (out_o.ready && o_single);
  assign en4 = (s4_mask_q == '0) || en5;
  assign en3 = (s3_mask_q == '0) || en4;
  assign en2 = (s2_mask_q == '0) || en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mask_q <= '0;
      s2_mask_q <= '0;
      s3_mask_q <= '0;
      s4_mask_q <= '0;
      o_mask_q  <= '0;
    end else begin
      if (acc)      s1_mask_q <= in_mask;
      else if (en2) s1_mask_q <= '0;
      if (en2) s2_mask_q <= s1_mask_q;
      if (en3) s3_mask_q <= s2_mask_q;
      if (en4) s4_mask_q <= s3_mask_q;
      if (en5)       o_mask_q <= s4_mask_q;
      else if (o_hs) o_mask_q <= o_mask_q & (o_mask_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_lx_q   <= lx_d;
      s2_ly_q   <= ly_d;
      s2_base_q <= base_d;
      s2_last_q <= s1_last_q;
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        s3_px_q[i] <= 54'($signed({1'b0, coef_x_q}) * s2_lx_q[i]);
        s3_py_q[i] <= 54'($signed({1'b0, coef_y_q}) * s2_ly_q[i]);
      end
      s3_base_q <= s2_base_q;
      s3_last_q <= s2_last_q;
    end
    if (en4) begin
      s4_term_q <= term_d;
      s4_base_q <= s3_base_q;
      s4_last_q <= s3_last_q;
    end
    if (en5) begin
      o_res_q  <= sat_d;
      o_last_q <= s4_last_q;
    end
  end

  assign out_o.valid     = (o_mask_q != '0);
  assign out_o.grid_done = o_last_q && o_single;
  always_comb begin
    if (o_mask_q[0])      out_o.new_value = o_res_q[0];
    else if (o_mask_q[1]) out_o.new_value = o_res_q[1];
    else                  out_o.new_value = o_res_q[2];
  end

endmodule

[sv/wes_checker.sv]
module wes_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input wes_pkg::value_t               new_value,
  input logic                          grid_done,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [wes_pkg::AddrWidth-1:0] paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready
);

  // the input only backs up behind a waiting result
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid) else $error("input stalled with no pending result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(new_value) && $stable(grid_done))
    else $error("result dropped or changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_coef_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[4:2] == wes_pkg::REG_COEF_X |=>
      paddr != $past(paddr) || prdata[17:0] == $past(pwdata[17:0]))
    else $error("coef_x readback mismatch");

endmodule

bind wave_equation_stencil_step wes_checker u_wes_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .new_value (out_o.new_value),
  .grid_done (out_o.grid_done),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

[sim/wave_equation_stencil_step_tb.sv]
`timescale 1ns / 100ps

module wave_equation_stencil_step_tb;

  typedef struct packed {
    logic [31:0] value;
    logic        done;
  } stencil_out_t;

  class StencilScoreboard;
    longint      row_width, row_count, coef_x, coef_y;
    bit          first_mirr, last_mirr;
    logic [31:0] older_row[1024];
    logic [31:0] newer_row[1024];
    logic [31:0] prior_row[1024];
    int          col, row;
    logic [31:0] held_cur, held_prev;
    stencil_out_t expected[$];
    int          errors;

    function new();
      row_width  = 64;
      row_count  = 64;
      coef_x     = 0;
      coef_y     = 0;
      first_mirr = 1;
      last_mirr  = 1;
      col        = 0;
      row        = 0;
      held_cur   = '0;
      held_prev  = '0;
      errors     = 0;
      for (int i = 0; i < 1024; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
        prior_row[i] = '0;
      end
    endfunction

    function longint sx(logic [31:0] v);
      return longint'($signed(v));
    endfunction

    function logic [31:0] stencil(longint u, longint lft, longint rgt, longint blw,
                                  longint abv, longint prv);
      longint lx, ly, s, term, res;
      lx   = lft - 2 * u + rgt;
      ly   = blw - 2 * u + abv;
      s    = coef_x * lx + coef_y * ly;
      term = (s + 32768) >>> 16;
      res  = 2 * u + term - prv;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res[31:0];
    endfunction

    function void configure(wes_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        wes_pkg::REG_ROW_WIDTH: begin
          row_width = val[10:0];
          col = 0;
          row = 0;
        end
        wes_pkg::REG_ROW_COUNT: begin
          row_count = val[12:0];
          col = 0;
          row = 0;
        end
        wes_pkg::REG_COEF_X:     coef_x = val[17:0];
        wes_pkg::REG_COEF_Y:     coef_y = val[17:0];
        wes_pkg::REG_FIRST_MIRR: first_mirr = val[0];
        wes_pkg::REG_LAST_MIRR:  last_mirr = val[0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [31:0] cur, logic [31:0] prv);
      longint      w, rows, u, p, lft, rgt, blw, ctr;
      int          c, r;
      bit          last;
      logic [31:0] vals[$];
      stencil_out_t e;
      w    = row_width < 2 ? 2 : (row_width > 1024 ? 1024 : row_width);
      rows = row_count < 3 ? 3 : (row_count > 4096 ? 4096 : row_count);
      c    = col >= w ? int'(w - 1) : col;
      r    = row >= rows ? int'(rows - 1) : row;
      u    = sx(cur);
      p    = sx(prv);
      last = (c == w - 1) && (r == rows - 1);
      if (r >= 1 && (r >= 2 || first_mirr)) begin
        ctr = sx(newer_row[c]);
        lft = (c == 0) ? sx(newer_row[1]) : sx(older_row[c-1]);
        rgt = (c == w - 1) ? sx(older_row[c-1]) : sx(newer_row[c+1]);
        blw = (r == 1) ? u : sx(older_row[c]);
        vals.push_back(stencil(ctr, lft, rgt, blw, u, sx(prior_row[c])));
      end
      older_row[c] = newer_row[c];
      newer_row[c] = cur;
      prior_row[c] = prv;
      if (r == rows - 1 && last_mirr) begin
        if (c >= 1) begin
          lft = (c == 1) ? u : sx(newer_row[c-2]);
          blw = sx(older_row[c-1]);
          vals.push_back(stencil(sx(held_cur), lft, u, blw, blw, sx(held_prev)));
        end
        if (c == w - 1) begin
          lft = sx(newer_row[c-1]);
          blw = sx(older_row[c]);
          vals.push_back(stencil(u, lft, lft, blw, blw, p));
        end
      end
      held_cur  = cur;
      held_prev = prv;
      foreach (vals[k]) begin
        e.value = vals[k];
        e.done  = last && (k == vals.size() - 1);
        expected.push_back(e);
      end
      if (c == w - 1) begin
        col = 0;
        row = (r == rows - 1) ? 0 : r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(logic [31:0] value, logic done);
      stencil_out_t e;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result %h done %b", value, done));
        return;
      end
      e = expected.pop_front();
      if (value !== e.value)
        report($sformatf("new_value %h, expected %h", value, e.value));
      if (done !== e.done)
        report($sformatf("grid_done %b, expected %b", done, e.done));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [wes_pkg::AddrWidth-1:0] paddr;
  logic [31:0] pwdata, prdata;
  bit          no_idle;
  bit          hold_req;
  int          hold_left;
  int          points_sent;

  StencilScoreboard sb;

  wes_in_if  in_bus ();
  wes_out_if out_bus ();

  wave_equation_stencil_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) sb.check(out_bus.new_value, out_bus.grid_done);
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  function logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task write_reg(wes_pkg::reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wes_pkg::AddrWidth'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.configure(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task setup_grid(logic [31:0] w, logic [31:0] rows, logic [31:0] cx, logic [31:0] cy,
                  logic fm, logic lm);
    drain();
    write_reg(wes_pkg::REG_ROW_WIDTH, w);
    write_reg(wes_pkg::REG_ROW_COUNT, rows);
    write_reg(wes_pkg::REG_COEF_X, cx);
    write_reg(wes_pkg::REG_COEF_Y, cy);
    write_reg(wes_pkg::REG_FIRST_MIRR, 32'(fm));
    write_reg(wes_pkg::REG_LAST_MIRR, 32'(lm));
  endtask

  task send_point(logic [31:0] cur, logic [31:0] prv, bit wait_empty);
    if (wait_empty || (!no_idle && $urandom_range(99) < 15)) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
      while (wait_empty && sb.expected.size() != 0) @(posedge clk_i);
      while (!no_idle && $urandom_range(99) < 15) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cur_value  <= cur;
    in_bus.prev_value <= prv;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(cur, prv);
    points_sent++;
  endtask

  task feed(int n, int pause_at);
    for (int i = 0; i < n; i++) send_point(rand_value(), rand_value(), i == pause_at);
  endtask

  initial begin
    int w, rows;
    sb           = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_bus.valid = 1'b0;
    in_bus.cur_value  = '0;
    in_bus.prev_value = '0;
    out_bus.ready = 1'b0;
    no_idle      = 0;
    hold_req     = 0;
    hold_left    = 0;
    points_sent  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturation in both directions, coefficients at full scale
    setup_grid(2, 3, 32'h3ffff, 32'h3ffff, 1'b1, 1'b1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 0);
    send_point(32'h0000_0000, 32'h0000_0000, 0);
    send_point(32'hffff_ffff, 32'h0000_0001, 0);
    // ghost first and last rows
    setup_grid(3, 3, 32'h10000, 32'h8000, 1'b0, 1'b0);
    feed(9, -1);
    // geometry below range is clamped
    setup_grid(1, 0, 32'h3ffff, 0, 1'b1, 1'b0);
    feed(6, -1);
    setup_grid(0, 2, 0, 32'h3ffff, 1'b0, 1'b1);
    feed(6, -1);

    for (int ph = 0; points_sent < 70; ph++) begin
      w    = $urandom_range(2, 6);
      rows = $urandom_range(3, 5);
      setup_grid(w, rows,
                 $urandom_range(0, 3) == 0 ? 32'h3ffff : $urandom_range(0, 32'h3ffff),
                 $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32'h3ffff),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (ph % 5 == 4) feed($urandom_range(1, w * rows), -1);
      else feed(w * rows * $urandom_range(1, 2), ph == 0 ? w + 1 : -1);
    end

    // output held off while the input keeps offering
    setup_grid(5, 6, $urandom_range(0, 32'h3ffff), $urandom_range(0, 32'h3ffff),
               1'b1, 1'b1);
    no_idle  = 1;
    hold_req = 1;
    feed(40, -1);
    no_idle = 0;
    // tallest grid, left unfinished
    setup_grid(2, 8191, 32'h3ffff, 32'h3ffff, 1'b1, 1'b1);
    feed(10, -1);
    setup_grid(1024, 4096, 0, 0, 1'b0, 1'b0);
    setup_grid(5, 4, 32'h4000, 32'h4000, 1'b1, 1'b1);
    feed(10, -1);
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
